// ===== rtl/core/imr_pkg.sv =====
// Shared types and constants for the IMU message frame receiver.
package imr_pkg;

	// Byte value that opens a frame after reset
	localparam logic [7:0] PREAMBLE_RESET = 8'hFA;

	// Record kinds
	localparam logic REC_PAYLOAD = 1'b0;
	localparam logic REC_END     = 1'b1;

	// Frame parser phases; the unused codes fall back to hunting
	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_BUS  = 3'd1,
		PH_ID   = 3'd2,
		PH_LEN  = 3'd3,
		PH_DATA = 3'd4,
		PH_SUM  = 3'd5
	} phase_t;

	// One result record
	typedef struct packed {
		logic       record_kind;
		logic [7:0] message_id;
		logic [7:0] payload_length;
		logic [7:0] byte_index;
		logic [7:0] payload_byte;
		logic       checksum_good;
	} rec_t;

endpackage

// ===== rtl/core/imr_input_stage.sv =====
// Input register stage: holds one received byte until the parser takes it.
module imr_input_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// Free when empty or when the held byte leaves this cycle
	assign in_ready = !valid_s1 || take;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== rtl/core/imr_frame_fsm.sv =====
// Frame parser: phase tracking, running sum and record generation.
module imr_frame_fsm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [7:0]    cfg_wr_data,
	input  logic          step,
	input  logic [7:0]    rx_b,
	output logic          has_rec,
	output imr_pkg::rec_t rec
);

	imr_pkg::phase_t phase_q, phase_d;
	logic [7:0] preamble_q;
	logic [7:0] sum_q, sum_d;
	logic [7:0] id_q, id_d;
	logic [7:0] len_q, len_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] sum_next;
	logic [7:0] seen_inc;

	assign sum_next = sum_q + rx_b;
	assign seen_inc = seen_q + 8'd1;

	// Preamble register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= imr_pkg::PREAMBLE_RESET;
		end else if (cfg_wr_en) begin
			preamble_q <= cfg_wr_data;
		end
	end

	// Next state and frame bookkeeping
	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		id_d    = id_q;
		len_d   = len_q;
		seen_d  = seen_q;
		unique case (phase_q)
			imr_pkg::PH_BUS: begin
				sum_d   = rx_b;
				phase_d = imr_pkg::PH_ID;
			end
			imr_pkg::PH_ID: begin
				id_d    = rx_b;
				sum_d   = sum_next;
				phase_d = imr_pkg::PH_LEN;
			end
			imr_pkg::PH_LEN: begin
				len_d   = rx_b;
				sum_d   = sum_next;
				seen_d  = 8'd0;
				phase_d = (rx_b == 8'd0) ? imr_pkg::PH_SUM : imr_pkg::PH_DATA;
			end
			imr_pkg::PH_DATA: begin
				sum_d  = sum_next;
				seen_d = seen_inc;
				if (seen_inc == len_q) begin
					phase_d = imr_pkg::PH_SUM;
				end
			end
			imr_pkg::PH_SUM: begin
				phase_d = imr_pkg::PH_HUNT;
				sum_d   = 8'd0;
				seen_d  = 8'd0;
			end
			default: begin
				// hunting, also reached from unused codes
				if (rx_b == preamble_q) begin
					sum_d   = 8'd0;
					phase_d = imr_pkg::PH_BUS;
				end else begin
					phase_d = imr_pkg::PH_HUNT;
				end
			end
		endcase
	end

	// Record for the current byte
	always_comb begin
		has_rec            = 1'b0;
		rec.record_kind    = imr_pkg::REC_PAYLOAD;
		rec.message_id     = id_q;
		rec.payload_length = len_q;
		rec.byte_index     = 8'd0;
		rec.payload_byte   = 8'd0;
		rec.checksum_good  = 1'b0;
		unique case (phase_q)
			imr_pkg::PH_DATA: begin
				has_rec          = 1'b1;
				rec.byte_index   = seen_q;
				rec.payload_byte = rx_b;
			end
			imr_pkg::PH_SUM: begin
				has_rec           = 1'b1;
				rec.record_kind   = imr_pkg::REC_END;
				rec.checksum_good = (sum_next == 8'd0);
			end
			default: begin
				has_rec = 1'b0;
			end
		endcase
	end

	// State registers, updated once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= imr_pkg::PH_HUNT;
			sum_q   <= 8'd0;
			id_q    <= 8'd0;
			len_q   <= 8'd0;
			seen_q  <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			id_q    <= id_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
		end
	end

endmodule

// ===== rtl/core/imr_output_reg.sv =====
// Result register: holds one record until the consumer takes it.
module imr_output_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  imr_pkg::rec_t rec_in,
	output logic          out_free,
	output logic          out_valid,
	input  logic          out_ready,
	output imr_pkg::rec_t rec_q
);

	// Room for a new record when empty or draining now
	assign out_free = !out_valid || out_ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	// Record payload
	always_ff @(posedge clk) begin
		if (out_free && load) begin
			rec_q <= rec_in;
		end
	end

endmodule

// ===== rtl/core/imu_message_frame_receiver_top.sv =====
// Top level of the IMU message frame receiver.
//
//  channel | signals                          | direction | per request
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid / in_ready              | in        | rx_byte
//  out     | out_valid / out_ready            | out       | record_kind .. checksum_good
//  cfg     | cfg_wr_en                        | in        | cfg_wr_data (preamble byte)
//
// One byte per cycle sustained while the output takes records; a byte passes the
// input register, the parser logic (8-bit adds and compares) and lands in the result
// register, so a record is on the output in the cycle after the parser takes its byte.
// Reset returns the parser to hunting and the preamble to 0xFA. A stalled output only
// holds back bytes that produce a record; header bytes keep flowing.
module imu_message_frame_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       record_kind,
	output logic [7:0] message_id,
	output logic [7:0] payload_length,
	output logic [7:0] byte_index,
	output logic [7:0] payload_byte,
	output logic       checksum_good
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          take;
	logic          has_rec;
	logic          out_free;
	imr_pkg::rec_t rec;
	imr_pkg::rec_t rec_q;

	// Held byte advances unless its record has nowhere to go
	assign take = valid_s1 && (!has_rec || out_free);

	imr_input_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	imr_frame_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (take),
		.rx_b        (byte_s1),
		.has_rec     (has_rec),
		.rec         (rec)
	);

	imr_output_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && has_rec),
		.rec_in    (rec),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rec_q     (rec_q)
	);

	// Record fields to ports
	assign record_kind    = rec_q.record_kind;
	assign message_id     = rec_q.message_id;
	assign payload_length = rec_q.payload_length;
	assign byte_index     = rec_q.byte_index;
	assign payload_byte   = rec_q.payload_byte;
	assign checksum_good  = rec_q.checksum_good;

endmodule

// ===== tb/tb.sv =====
// Testbench for the IMU message frame receiver: directed frames, random frames, stall mixes.
`timescale 1ns / 1ps

module tb;

	// One directed stimulus row: the byte and, where it is obvious, the record it yields
	typedef struct packed {
		logic [7:0]    rx;
		logic          typed;
		imr_pkg::rec_t lit;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       record_kind;
	logic [7:0] message_id;
	logic [7:0] payload_length;
	logic [7:0] byte_index;
	logic [7:0] payload_byte;
	logic       checksum_good;

	// Typed expectation travelling with the current request
	logic          row_typed = 1'b0;
	imr_pkg::rec_t row_rec = '0;

	// Frame parser mirror
	imr_pkg::phase_t pred_phase = imr_pkg::PH_HUNT;
	logic [7:0] pred_sum = 8'h00;
	logic [7:0] pred_id = 8'h00;
	logic [7:0] pred_len = 8'h00;
	logic [7:0] pred_seen = 8'h00;
	logic [7:0] preamble_copy = imr_pkg::PREAMBLE_RESET;

	imr_pkg::rec_t pending_records [$];
	stim_row_t     dir_rows [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatch_count = 0;
	int bytes_sent = 0;
	int records_checked = 0;
	int frames_good = 0;
	int frames_bad = 0;
	logic [7:0] last_preamble;

	imu_message_frame_receiver_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.record_kind    (record_kind),
		.message_id     (message_id),
		.payload_length (payload_length),
		.byte_index     (byte_index),
		.payload_byte   (payload_byte),
		.checksum_good  (checksum_good)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic imr_pkg::rec_t mk_rec(input logic kind, input logic [7:0] id,
		input logic [7:0] len, input logic [7:0] idx, input logic [7:0] data,
		input logic good);
		imr_pkg::rec_t r;
		r.record_kind = kind;
		r.message_id = id;
		r.payload_length = len;
		r.byte_index = idx;
		r.payload_byte = data;
		r.checksum_good = good;
		return r;
	endfunction

	function automatic stim_row_t row(input logic [7:0] rx, input logic typed,
		input imr_pkg::rec_t lit);
		stim_row_t s;
		s.rx = rx;
		s.typed = typed;
		s.lit = lit;
		return s;
	endfunction

	// Advance the frame parser mirror by one byte; made is set when a record results
	function automatic void parse_rx_byte(input logic [7:0] b, output bit made,
		output imr_pkg::rec_t r);
		made = 1'b0;
		r = '0;
		case (pred_phase)
			imr_pkg::PH_BUS: begin
				pred_sum = b;
				pred_phase = imr_pkg::PH_ID;
			end
			imr_pkg::PH_ID: begin
				pred_id = b;
				pred_sum = pred_sum + b;
				pred_phase = imr_pkg::PH_LEN;
			end
			imr_pkg::PH_LEN: begin
				pred_len = b;
				pred_sum = pred_sum + b;
				pred_seen = 8'h00;
				pred_phase = (b == 8'h00) ? imr_pkg::PH_SUM : imr_pkg::PH_DATA;
			end
			imr_pkg::PH_DATA: begin
				pred_sum = pred_sum + b;
				r = mk_rec(imr_pkg::REC_PAYLOAD, pred_id, pred_len, pred_seen, b, 1'b0);
				made = 1'b1;
				pred_seen = pred_seen + 8'h01;
				if (pred_seen == pred_len)
					pred_phase = imr_pkg::PH_SUM;
			end
			imr_pkg::PH_SUM: begin
				pred_sum = pred_sum + b;
				r = mk_rec(imr_pkg::REC_END, pred_id, pred_len, 8'h00, 8'h00,
					pred_sum == 8'h00);
				made = 1'b1;
				pred_phase = imr_pkg::PH_HUNT;
				pred_sum = 8'h00;
				pred_seen = 8'h00;
			end
			default: begin
				// hunting: only the preamble opens a frame
				if (b == preamble_copy) begin
					pred_sum = 8'h00;
					pred_phase = imr_pkg::PH_BUS;
				end else begin
					pred_phase = imr_pkg::PH_HUNT;
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch(name, int'(got), int'(want));
	endtask

	// Receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle_pct);

	// Sample both channels and the register port at the rising edge
	always @(posedge clk) begin : watch_edges
		bit            made;
		imr_pkg::rec_t pred;
		imr_pkg::rec_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				preamble_copy = cfg_wr_data;
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte, made, pred);
				if (row_typed)
					pending_records.push_back(row_rec);
				else if (made)
					pending_records.push_back(pred);
			end
			if (out_valid && out_ready) begin
				if (pending_records.size() == 0) begin
					report_mismatch("record with nothing pending", int'(record_kind), 0);
				end else begin
					want = pending_records.pop_front();
					records_checked++;
					check_field("record_kind", 8'(record_kind), 8'(want.record_kind));
					check_field("message_id", message_id, want.message_id);
					check_field("payload_length", payload_length, want.payload_length);
					check_field("byte_index", byte_index, want.byte_index);
					check_field("payload_byte", payload_byte, want.payload_byte);
					check_field("checksum_good", 8'(checksum_good), 8'(want.checksum_good));
					if (want.record_kind == imr_pkg::REC_END) begin
						if (want.checksum_good)
							frames_good++;
						else
							frames_bad++;
					end
				end
			end
		end
	end

	// One request on the input channel; entered and left just after a falling edge
	task automatic send_byte(input logic [7:0] b, input logic typed, input imr_pkg::rec_t lit);
		int gaps;
		gaps = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gaps++;
		if (gaps > 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		row_typed <= typed;
		row_rec <= lit;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Let every pending record out, then give header bytes time to clear the pipe
	task automatic drain_requests();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_records.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (6) @(negedge clk);
	endtask

	task automatic set_preamble(input logic [7:0] v);
		drain_requests();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// A well-formed frame with random content, a corrupt checksum, or a burst of noise
	task automatic send_random_frame(input int forced_len);
		logic [7:0] sum;
		logic [7:0] len;
		logic [7:0] b;
		int pick;
		int n_noise;
		pick = $urandom_range(99);
		if (forced_len < 0 && pick < 8) begin
			n_noise = $urandom_range(1, 3);
			repeat (n_noise) send_byte(8'($urandom_range(255)), 1'b0, '0);
		end else begin
			if (forced_len >= 0)
				len = 8'(forced_len);
			else if (pick < 10)
				len = 8'($urandom_range(200, 255));
			else if (pick < 22)
				len = 8'($urandom_range(9, 40));
			else
				len = 8'($urandom_range(0, 8));
			send_byte(preamble_copy, 1'b0, '0);
			b = 8'($urandom_range(255));
			send_byte(b, 1'b0, '0);
			sum = b;
			b = 8'($urandom_range(255));
			send_byte(b, 1'b0, '0);
			sum = sum + b;
			send_byte(len, 1'b0, '0);
			sum = sum + len;
			repeat (len) begin
				b = 8'($urandom_range(255));
				send_byte(b, 1'b0, '0);
				sum = sum + b;
			end
			if (forced_len >= 0 || $urandom_range(99) < 85)
				b = 8'h00 - sum;
			else
				b = 8'($urandom_range(255));
			send_byte(b, 1'b0, '0);
		end
	endtask

	task automatic run_random(input int n_items);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_items)
			send_random_frame(-1);
	endtask

	// Stimulus
	initial begin
		// reset preamble 0xFA; noise, zero length, preamble as data, bad checksum, extremes
		dir_rows.push_back(row(8'h00, 1'b0, '0));
		dir_rows.push_back(row(8'hFF, 1'b0, '0));
		dir_rows.push_back(row(8'hFA, 1'b0, '0));
		dir_rows.push_back(row(8'h00, 1'b0, '0));
		dir_rows.push_back(row(8'h01, 1'b0, '0));
		dir_rows.push_back(row(8'h00, 1'b0, '0));
		dir_rows.push_back(row(8'hFF, 1'b1,
			mk_rec(imr_pkg::REC_END, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1)));
		dir_rows.push_back(row(8'hFA, 1'b0, '0));
		dir_rows.push_back(row(8'hFF, 1'b0, '0));
		dir_rows.push_back(row(8'hFF, 1'b0, '0));
		dir_rows.push_back(row(8'h02, 1'b0, '0));
		dir_rows.push_back(row(8'hFA, 1'b1,
			mk_rec(imr_pkg::REC_PAYLOAD, 8'hFF, 8'h02, 8'h00, 8'hFA, 1'b0)));
		dir_rows.push_back(row(8'h00, 1'b0, '0));
		dir_rows.push_back(row(8'h06, 1'b1,
			mk_rec(imr_pkg::REC_END, 8'hFF, 8'h02, 8'h00, 8'h00, 1'b1)));
		dir_rows.push_back(row(8'hFA, 1'b0, '0));
		dir_rows.push_back(row(8'h12, 1'b0, '0));
		dir_rows.push_back(row(8'h34, 1'b0, '0));
		dir_rows.push_back(row(8'h01, 1'b0, '0));
		dir_rows.push_back(row(8'hAA, 1'b0, '0));
		dir_rows.push_back(row(8'h00, 1'b1,
			mk_rec(imr_pkg::REC_END, 8'h34, 8'h01, 8'h00, 8'h00, 1'b0)));
		dir_rows.push_back(row(8'hFA, 1'b0, '0));
		dir_rows.push_back(row(8'h00, 1'b0, '0));
		dir_rows.push_back(row(8'h80, 1'b0, '0));
		dir_rows.push_back(row(8'h01, 1'b0, '0));
		dir_rows.push_back(row(8'hFF, 1'b0, '0));
		dir_rows.push_back(row(8'h80, 1'b0, '0));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles lightly, receiver heavily
		tx_idle_pct = 26;
		rx_idle_pct = 80;
		foreach (dir_rows[i])
			send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].lit);
		set_preamble(8'h00);
		send_random_frame(255);
		run_random(540);

		// the other way round
		set_preamble(8'hFF);
		tx_idle_pct = 80;
		rx_idle_pct = 26;
		run_random(540);

		// full rate on both sides
		last_preamble = 8'($urandom_range(1, 254));
		set_preamble(last_preamble);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(540);

		drain_requests();
		if (pending_records.size() != 0)
			report_mismatch("records never delivered", pending_records.size(), 0);

		$display("sent %0d bytes, checked %0d records, closed %0d frames (%0d good, %0d bad)",
			bytes_sent, records_checked, frames_good + frames_bad, frames_good, frames_bad);
		$display("preambles 0xFA, 0x00, 0xFF, 0x%0h under three stall mixes", last_preamble);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== imu_message_frame_receiver_top.f =====
rtl/core/imr_pkg.sv
rtl/core/imr_input_stage.sv
rtl/core/imr_frame_fsm.sv
rtl/core/imr_output_reg.sv
rtl/core/imu_message_frame_receiver_top.sv
tb/tb.sv
